>>> design/tct_pkg.sv
// Shared types, codes and constants of the terminal cursor tracker.
`timescale 1ns / 1ps

package tct_pkg;

    // Tab stop spacing and the largest step count that relative motion may use
    localparam int TAB_WIDTH      = 8;
    localparam int RELATIVE_LIMIT = 5;
    localparam int STEP_BUDGET    = 7;
    localparam int MOVE_LIMIT     = (RELATIVE_LIMIT < STEP_BUDGET) ? RELATIVE_LIMIT
                                                                   : STEP_BUDGET;
    // Most spaces that tab padding may send
    localparam int PAD_MAX        = 8;

    // Command codes
    localparam logic [1:0] CMD_WRITE      = 2'd0;
    localparam logic [1:0] CMD_MOVE       = 2'd1;
    localparam logic [1:0] CMD_CLEAR      = 2'd2;
    localparam logic [1:0] CMD_INVALIDATE = 2'd3;

    // Token kinds
    localparam logic [2:0] TK_BYTE  = 3'd0;
    localparam logic [2:0] TK_LEFT  = 3'd1;
    localparam logic [2:0] TK_RIGHT = 3'd2;
    localparam logic [2:0] TK_UP    = 3'd3;
    localparam logic [2:0] TK_DOWN  = 3'd4;
    localparam logic [2:0] TK_GOTO  = 3'd5;
    localparam logic [2:0] TK_CLEAR = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_MAX_LINE       = 3'd0;
    localparam logic [2:0] REG_NUM_COLS       = 3'd1;
    localparam logic [2:0] REG_AUTO_MARGIN    = 3'd2;
    localparam logic [2:0] REG_NEWLINE_GLITCH = 3'd3;
    localparam logic [2:0] REG_HARDWARE_TABS  = 3'd4;
    localparam logic [2:0] REG_VERTICAL_MOVES = 3'd5;

    // Configuration reset values
    localparam logic [7:0] RST_MAX_LINE = 8'd23;
    localparam logic [7:0] RST_NUM_COLS = 8'd80;

    // Character codes
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_0226  = 8'o226;

    // One command beat
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] byte_value;
        logic [7:0] target_line;
        logic [7:0] target_col;
    } cmd_t;

    // One token beat
    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] token_byte;
        logic [7:0] goto_line;
        logic [7:0] goto_col;
        logic       last_token;
    } tok_t;

endpackage

>>> design/terminal_cursor_tracker.sv
// Top level of the terminal cursor tracker: sequencer, shared subtractor and token queue.
`timescale 1ns / 1ps

// Usage
//   cmd channel (cmd_valid, cmd_stall, cmd): one command per beat, taken at a
//   rising edge with cmd_valid high and cmd_stall low. tok channel (tok_valid,
//   tok_stall, tok): tokens of the command in order, last_token marking the
//   final one; a command may send no token.
//   cfg port (cfg_we, cfg_index, cfg_data): write a register while idle.
// Timing
//   A write, clear or invalidate goes from idle straight to planning; a move
//   first passes through SATL, SATC, DCOL and DLINE, since the one shared
//   subtractor saturates line and column and then forms the column and line
//   distances in turn. Tokens then leave one per cycle while tok_stall allows,
//   and the sequencer steps over empty queue segments on the way. cmd_stall
//   stays high until the last token of a command sits in the output register.
// Reset
//   rst_n clears the cursor to line 0, column 0, unknown, and loads the
//   register defaults. No clearing pass is needed.
// Back-pressure
//   While tok_stall is high the output register holds its token and the
//   sequencer waits; the next command may still be taken once the last
//   token is waiting there.
module terminal_cursor_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  tct_pkg::cmd_t     cmd,
    output logic              tok_valid,
    input  logic              tok_stall,
    output tct_pkg::tok_t     tok,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SATL  = 3'd1;
    localparam logic [2:0] ST_SATC  = 3'd2;
    localparam logic [2:0] ST_DCOL  = 3'd3;
    localparam logic [2:0] ST_DLINE = 3'd4;
    localparam logic [2:0] ST_PLAN  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    localparam int NSEG = 4;

    // Configuration
    logic [7:0] max_line_reg;
    logic [7:0] num_cols_reg;
    logic       auto_margin_reg;
    logic       newline_glitch_reg;
    logic       hardware_tabs_reg;
    logic       vertical_moves_reg;

    // Cursor state
    logic [7:0] cur_line_reg, cur_line_next;
    logic [7:0] cur_col_reg, cur_col_next;
    logic       known_reg, known_next;
    logic       wrapped_reg, wrapped_next;

    // Sequencer and latched command
    logic [2:0] state_reg, state_next;
    logic [1:0] command_reg;
    logic [7:0] byte_reg;
    logic [7:0] tline_reg, tline_next;
    logic [7:0] tcol_reg, tcol_next;
    logic [8:0] dc_reg, dc_next;
    logic [8:0] dl_reg, dl_next;

    // Token queue: segments of repeated tokens
    logic [2:0] seg_kind_reg [NSEG];
    logic [2:0] seg_kind_next [NSEG];
    logic [7:0] seg_byte_reg [NSEG];
    logic [7:0] seg_byte_next [NSEG];
    logic [3:0] seg_cnt_reg [NSEG];
    logic [3:0] seg_cnt_next [NSEG];
    logic [1:0] seg_idx_reg, seg_idx_next;
    logic [3:0] remain_reg, remain_next;
    logic [7:0] goto_line_reg, goto_line_next;
    logic [7:0] goto_col_reg, goto_col_next;

    // Output register
    logic          tok_valid_reg, tok_valid_next;
    tct_pkg::tok_t tok_reg, tok_next;

    // Shared subtractor
    logic [7:0] alu_a, alu_b;
    logic [8:0] alu_diff;

    // Planning helpers
    logic [7:0] last_col;
    logic [7:0] line_inc;
    logic [7:0] mapped_ch;
    logic [8:0] next_tab;
    logic [8:0] pad_raw;
    logic [3:0] pad_cnt;
    logic [8:0] dc_eff;
    logic [7:0] abs_dc, abs_dl;
    logic [8:0] step_dist;
    logic       cr_needed;
    logic [3:0] plan_total;
    logic       slot_free;
    logic       fire;
    logic       cmd_accept;

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign tok_valid  = tok_valid_reg;
    assign tok        = tok_reg;

    assign slot_free = !tok_valid_reg || !tok_stall;
    assign fire      = (state_reg == ST_EMIT) && (seg_cnt_reg[seg_idx_reg] != 4'd0)
                       && slot_free;

    // Derive margin and line helpers
    assign last_col = (num_cols_reg == 8'd0) ? 8'd0 : num_cols_reg - 8'd1;
    assign line_inc = (cur_line_reg < max_line_reg) ? cur_line_reg + 8'd1 : cur_line_reg;
    assign mapped_ch = ((byte_reg < tct_pkg::CH_SPACE) || (byte_reg == tct_pkg::CH_DEL)
                        || (byte_reg == tct_pkg::CH_0226)) ? tct_pkg::CH_QUERY : byte_reg;

    // Next tab stop and padding length
    assign next_tab = 9'(({1'b0, cur_col_reg} / tct_pkg::TAB_WIDTH + 9'd1)
                         * tct_pkg::TAB_WIDTH);
    assign pad_raw  = next_tab - {1'b0, cur_col_reg};
    assign pad_cnt  = (pad_raw > 9'(tct_pkg::PAD_MAX)) ? 4'(tct_pkg::PAD_MAX) : pad_raw[3:0];

    // Distances for relative motion
    assign cr_needed = (tcol_reg == 8'd0) && (cur_col_reg != 8'd0);
    assign dc_eff    = (tcol_reg == 8'd0) ? 9'd0 : dc_reg;
    assign abs_dc    = dc_eff[8] ? 8'(-dc_eff) : dc_eff[7:0];
    assign abs_dl    = dl_reg[8] ? 8'(-dl_reg) : dl_reg[7:0];
    assign step_dist = {1'b0, abs_dc} + {1'b0, abs_dl};

    // Select operands of the shared subtractor
    always_comb
    begin
        alu_a = 8'd0;
        alu_b = 8'd0;
        unique case (state_reg)
            ST_SATL:
            begin
                alu_a = max_line_reg;
                alu_b = tline_reg;
            end
            ST_SATC:
            begin
                alu_a = last_col;
                alu_b = tcol_reg;
            end
            ST_DCOL:
            begin
                alu_a = tcol_reg;
                alu_b = cur_col_reg;
            end
            ST_DLINE:
            begin
                alu_a = tline_reg;
                alu_b = cur_line_reg;
            end
            default:
            begin
                alu_a = 8'd0;
                alu_b = 8'd0;
            end
        endcase
    end

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};

    // Sequencer, planner and token issue
    always_comb
    begin
        state_next     = state_reg;
        cur_line_next  = cur_line_reg;
        cur_col_next   = cur_col_reg;
        known_next     = known_reg;
        wrapped_next   = wrapped_reg;
        tline_next     = tline_reg;
        tcol_next      = tcol_reg;
        dc_next        = dc_reg;
        dl_next        = dl_reg;
        seg_idx_next   = seg_idx_reg;
        remain_next    = remain_reg;
        goto_line_next = goto_line_reg;
        goto_col_next  = goto_col_reg;
        tok_next       = tok_reg;
        plan_total     = 4'd0;
        for (int i = 0; i < NSEG; i++)
        begin
            seg_kind_next[i] = seg_kind_reg[i];
            seg_byte_next[i] = seg_byte_reg[i];
            seg_cnt_next[i]  = seg_cnt_reg[i];
        end

        // Drop a taken token, load a new one when issued
        tok_valid_next = tok_valid_reg && tok_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    tline_next = cmd.target_line;
                    tcol_next  = cmd.target_col;
                    state_next = (cmd.command == tct_pkg::CMD_MOVE) ? ST_SATL : ST_PLAN;
                end
            end
            ST_SATL:
            begin
                if (alu_diff[8])
                begin
                    tline_next = max_line_reg;
                end
                state_next = ST_SATC;
            end
            ST_SATC:
            begin
                if (alu_diff[8])
                begin
                    tcol_next = last_col;
                end
                state_next = ST_DCOL;
            end
            ST_DCOL:
            begin
                dc_next    = alu_diff;
                state_next = ST_DLINE;
            end
            ST_DLINE:
            begin
                dl_next    = alu_diff;
                state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                for (int i = 0; i < NSEG; i++)
                begin
                    seg_kind_next[i] = tct_pkg::TK_BYTE;
                    seg_byte_next[i] = 8'd0;
                    seg_cnt_next[i]  = 4'd0;
                end
                goto_line_next = 8'd0;
                goto_col_next  = 8'd0;

                unique case (command_reg)
                    tct_pkg::CMD_WRITE:
                    begin
                        wrapped_next = 1'b0;
                        unique case (byte_reg)
                            tct_pkg::CH_CR:
                            begin
                                if (wrapped_reg)
                                begin
                                    wrapped_next = 1'b1;
                                end
                                else
                                begin
                                    seg_byte_next[0] = tct_pkg::CH_CR;
                                    seg_cnt_next[0]  = 4'd1;
                                    cur_col_next     = 8'd0;
                                end
                            end
                            tct_pkg::CH_LF:
                            begin
                                if (!wrapped_reg)
                                begin
                                    seg_byte_next[0] = tct_pkg::CH_LF;
                                    seg_cnt_next[0]  = 4'd1;
                                    cur_line_next    = line_inc;
                                end
                            end
                            tct_pkg::CH_BS:
                            begin
                                if (!known_reg)
                                begin
                                    seg_kind_next[0] = tct_pkg::TK_LEFT;
                                    seg_cnt_next[0]  = 4'd1;
                                end
                                else if (cur_col_reg != 8'd0)
                                begin
                                    seg_kind_next[0] = tct_pkg::TK_LEFT;
                                    seg_cnt_next[0]  = 4'd1;
                                    cur_col_next     = cur_col_reg - 8'd1;
                                end
                                else if (cur_line_reg != 8'd0)
                                begin
                                    seg_kind_next[3] = tct_pkg::TK_GOTO;
                                    seg_cnt_next[3]  = 4'd1;
                                    goto_line_next   = cur_line_reg - 8'd1;
                                    goto_col_next    = last_col;
                                    cur_line_next    = cur_line_reg - 8'd1;
                                    cur_col_next     = last_col;
                                end
                            end
                            tct_pkg::CH_BEL:
                            begin
                                seg_byte_next[0] = tct_pkg::CH_BEL;
                                seg_cnt_next[0]  = 4'd1;
                            end
                            tct_pkg::CH_TAB:
                            begin
                                if (!known_reg)
                                begin
                                    seg_byte_next[0] = hardware_tabs_reg ? tct_pkg::CH_TAB
                                                                         : tct_pkg::CH_SPACE;
                                    seg_cnt_next[0]  = 4'd1;
                                end
                                else if (next_tab >= {1'b0, num_cols_reg})
                                begin
                                    seg_byte_next[0] = tct_pkg::CH_CR;
                                    seg_cnt_next[0]  = 4'd1;
                                    seg_byte_next[1] = tct_pkg::CH_LF;
                                    seg_cnt_next[1]  = 4'd1;
                                    cur_col_next     = 8'd0;
                                    cur_line_next    = line_inc;
                                end
                                else if (hardware_tabs_reg)
                                begin
                                    seg_byte_next[0] = tct_pkg::CH_TAB;
                                    seg_cnt_next[0]  = 4'd1;
                                    cur_col_next     = next_tab[7:0];
                                end
                                else
                                begin
                                    seg_byte_next[0] = tct_pkg::CH_SPACE;
                                    seg_cnt_next[0]  = pad_cnt;
                                    cur_col_next     = cur_col_reg + 8'(pad_cnt);
                                end
                            end
                            default:
                            begin
                                seg_byte_next[0] = mapped_ch;
                                seg_cnt_next[0]  = 4'd1;
                                if (known_reg && (cur_col_reg >= last_col))
                                begin
                                    // Wrap at the right margin
                                    if (!auto_margin_reg || newline_glitch_reg)
                                    begin
                                        seg_byte_next[1] = tct_pkg::CH_CR;
                                        seg_cnt_next[1]  = 4'd1;
                                        seg_byte_next[2] = tct_pkg::CH_LF;
                                        seg_cnt_next[2]  = 4'd1;
                                    end
                                    cur_line_next = line_inc;
                                    cur_col_next  = 8'd0;
                                    wrapped_next  = 1'b1;
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg + 8'd1;
                                end
                            end
                        endcase
                    end
                    tct_pkg::CMD_MOVE:
                    begin
                        if (!known_reg)
                        begin
                            seg_kind_next[3] = tct_pkg::TK_GOTO;
                            seg_cnt_next[3]  = 4'd1;
                            goto_line_next   = tline_reg;
                            goto_col_next    = tcol_reg;
                            cur_line_next    = tline_reg;
                            cur_col_next     = tcol_reg;
                            known_next       = 1'b1;
                        end
                        else if ((tcol_reg != cur_col_reg) || (tline_reg != cur_line_reg))
                        begin
                            // Carriage return shortcut to column zero
                            if (cr_needed)
                            begin
                                seg_byte_next[0] = tct_pkg::CH_CR;
                                seg_cnt_next[0]  = 4'd1;
                                cur_col_next     = 8'd0;
                            end
                            if ((tcol_reg == 8'd0) && (dl_reg == 9'd0))
                            begin
                                cur_col_next = 8'd0;
                            end
                            else if ((tcol_reg == 8'd0) && (dl_reg == 9'd1))
                            begin
                                seg_byte_next[2] = tct_pkg::CH_LF;
                                seg_cnt_next[2]  = 4'd1;
                                cur_line_next    = tline_reg;
                            end
                            else if (step_dist > 9'(tct_pkg::MOVE_LIMIT))
                            begin
                                seg_kind_next[3] = tct_pkg::TK_GOTO;
                                seg_cnt_next[3]  = 4'd1;
                                goto_line_next   = tline_reg;
                                goto_col_next    = tcol_reg;
                                cur_line_next    = tline_reg;
                                cur_col_next     = tcol_reg;
                            end
                            else
                            begin
                                // Relative steps, horizontal then vertical
                                seg_kind_next[1] = dc_eff[8] ? tct_pkg::TK_LEFT
                                                             : tct_pkg::TK_RIGHT;
                                seg_cnt_next[1]  = abs_dc[3:0];
                                cur_col_next     = tcol_reg;
                                if (dl_reg != 9'd0)
                                begin
                                    cur_line_next = tline_reg;
                                    if (!vertical_moves_reg)
                                    begin
                                        seg_kind_next[3] = tct_pkg::TK_GOTO;
                                        seg_cnt_next[3]  = 4'd1;
                                        goto_line_next   = tline_reg;
                                        goto_col_next    = tcol_reg;
                                    end
                                    else
                                    begin
                                        seg_kind_next[2] = dl_reg[8] ? tct_pkg::TK_UP
                                                                     : tct_pkg::TK_DOWN;
                                        seg_cnt_next[2]  = abs_dl[3:0];
                                    end
                                end
                            end
                        end
                    end
                    tct_pkg::CMD_CLEAR:
                    begin
                        seg_kind_next[0] = tct_pkg::TK_CLEAR;
                        seg_cnt_next[0]  = 4'd1;
                        cur_line_next    = 8'd0;
                        cur_col_next     = 8'd0;
                        known_next       = 1'b1;
                    end
                    tct_pkg::CMD_INVALIDATE:
                    begin
                        cur_line_next = 8'd0;
                        cur_col_next  = 8'd0;
                        known_next    = 1'b0;
                    end
                    default:
                    begin
                        known_next = known_reg;
                    end
                endcase

                plan_total   = seg_cnt_next[0] + seg_cnt_next[1] + seg_cnt_next[2]
                               + seg_cnt_next[3];
                seg_idx_next = 2'd0;
                remain_next  = plan_total;
                state_next   = (plan_total == 4'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (seg_cnt_reg[seg_idx_reg] == 4'd0)
                begin
                    // Step over an empty segment
                    seg_idx_next = seg_idx_reg + 2'd1;
                end
                else if (slot_free)
                begin
                    tok_valid_next      = 1'b1;
                    tok_next.token_kind = seg_kind_reg[seg_idx_reg];
                    tok_next.token_byte = (seg_kind_reg[seg_idx_reg] == tct_pkg::TK_BYTE)
                                          ? seg_byte_reg[seg_idx_reg] : 8'd0;
                    tok_next.goto_line  = (seg_kind_reg[seg_idx_reg] == tct_pkg::TK_GOTO)
                                          ? goto_line_reg : 8'd0;
                    tok_next.goto_col   = (seg_kind_reg[seg_idx_reg] == tct_pkg::TK_GOTO)
                                          ? goto_col_reg : 8'd0;
                    tok_next.last_token = (remain_reg == 4'd1);
                    seg_cnt_next[seg_idx_reg] = seg_cnt_reg[seg_idx_reg] - 4'd1;
                    remain_next = remain_reg - 4'd1;
                    if (remain_reg == 4'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cur_line_reg       <= 8'd0;
            cur_col_reg        <= 8'd0;
            known_reg          <= 1'b0;
            wrapped_reg        <= 1'b0;
            seg_idx_reg        <= 2'd0;
            remain_reg         <= 4'd0;
            tok_valid_reg      <= 1'b0;
            max_line_reg       <= tct_pkg::RST_MAX_LINE;
            num_cols_reg       <= tct_pkg::RST_NUM_COLS;
            auto_margin_reg    <= 1'b1;
            newline_glitch_reg <= 1'b0;
            hardware_tabs_reg  <= 1'b1;
            vertical_moves_reg <= 1'b1;
            for (int i = 0; i < NSEG; i++)
            begin
                seg_cnt_reg[i] <= 4'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_line_reg  <= cur_line_next;
            cur_col_reg   <= cur_col_next;
            known_reg     <= known_next;
            wrapped_reg   <= wrapped_next;
            seg_idx_reg   <= seg_idx_next;
            remain_reg    <= remain_next;
            tok_valid_reg <= tok_valid_next;
            for (int i = 0; i < NSEG; i++)
            begin
                seg_cnt_reg[i] <= seg_cnt_next[i];
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tct_pkg::REG_MAX_LINE:       max_line_reg       <= cfg_data;
                    tct_pkg::REG_NUM_COLS:       num_cols_reg       <= cfg_data;
                    tct_pkg::REG_AUTO_MARGIN:    auto_margin_reg    <= cfg_data[0];
                    tct_pkg::REG_NEWLINE_GLITCH: newline_glitch_reg <= cfg_data[0];
                    tct_pkg::REG_HARDWARE_TABS:  hardware_tabs_reg  <= cfg_data[0];
                    tct_pkg::REG_VERTICAL_MOVES: vertical_moves_reg <= cfg_data[0];
                    default:
                    begin
                        max_line_reg <= max_line_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            command_reg <= cmd.command;
            byte_reg    <= cmd.byte_value;
        end
        tline_reg     <= tline_next;
        tcol_reg      <= tcol_next;
        dc_reg        <= dc_next;
        dl_reg        <= dl_next;
        goto_line_reg <= goto_line_next;
        goto_col_reg  <= goto_col_next;
        tok_reg       <= tok_next;
        for (int i = 0; i < NSEG; i++)
        begin
            seg_kind_reg[i] <= seg_kind_next[i];
            seg_byte_reg[i] <= seg_byte_next[i];
        end
    end

    // The remaining count always matches what the queue still holds
    a_remain_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (remain_reg == 4'(seg_cnt_reg[0] + seg_cnt_reg[1]
                                                     + seg_cnt_reg[2] + seg_cnt_reg[3])))
        else $error("token count out of step with queue");

    // An accepted command always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> (state_reg != ST_IDLE))
        else $error("command accepted without starting work");

    // The beat marked last ends the command
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (remain_reg == 4'd1)) |=> ((state_reg == ST_IDLE) && tok_valid_reg
                                            && tok_reg.last_token))
        else $error("last token did not close the command");

    // Tokens are only issued while emitting
    a_issue_state: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(tok_valid_reg)) |-> ($past(state_reg) == ST_EMIT))
        else $error("token issued outside the emit phase");

endmodule
